@@ rtl/kcpn_pkg.sv @@
// ----------------------------------------------------------------------------
// kcpn_pkg
// Shared types, sizes and helpers for the Kronecker column projection norm.
// ----------------------------------------------------------------------------
package kcpn_pkg;

    localparam int MAX_SENSORS  = 16;
    localparam int MAX_SOURCES  = 16;
    localparam int MAX_TIME     = 32;

    localparam int SEN_W        = $clog2(MAX_SENSORS);
    localparam int SRC_W        = $clog2(MAX_SOURCES);
    localparam int TIME_W       = $clog2(MAX_TIME);

    localparam int GAIN_DEPTH   = MAX_SENSORS * MAX_SOURCES;
    localparam int GAIN_AW      = $clog2(GAIN_DEPTH);
    localparam int WEIGHT_DEPTH = 2 * MAX_SOURCES * MAX_SOURCES;
    localparam int WEIGHT_AW    = $clog2(WEIGHT_DEPTH);
    localparam int ROW_STRIDE   = 2 * MAX_SENSORS * MAX_SENSORS;
    localparam int ROW_W        = $clog2(ROW_STRIDE);
    localparam int PROJ_DEPTH   = MAX_TIME * ROW_STRIDE;
    localparam int PROJ_AW      = $clog2(PROJ_DEPTH);
    localparam int COL_DEPTH    = MAX_SENSORS * MAX_SENSORS;
    localparam int COL_AW       = $clog2(COL_DEPTH);

    localparam int APB_AW       = 4;

    typedef enum logic [1:0] {
        FUNC_GAIN    = 2'd0,
        FUNC_WEIGHT  = 2'd1,
        FUNC_PROJ    = 2'd2,
        FUNC_COMPUTE = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        REG_SENSORS   = 2'd0,
        REG_SOURCES   = 2'd1,
        REG_TIME      = 2'd2,
        REG_THRESHOLD = 2'd3
    } t_reg;

    typedef struct packed {
        logic [1:0]         func;
        logic [13:0]        addr;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic [8:0]         column_index;
        logic signed [31:0] violation;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_DIV,
        S_CB_RDL,
        S_CB_RDK,
        S_CB_MUL1,
        S_CB_MUL2,
        S_CB_MUL3,
        S_CB_WR,
        S_MAC,
        S_ROW_END,
        S_SQ,
        S_ACC,
        S_SQRT,
        S_DONE
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        if (x > 66'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (x < -66'sd2147483648) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    function automatic logic [4:0] clamp5(input logic [4:0] v, input logic [4:0] hi);
        if (v == 5'd0) begin
            return 5'd1;
        end
        return (v > hi) ? hi : v;
    endfunction

    function automatic logic [5:0] clamp6(input logic [5:0] v, input logic [5:0] hi);
        if (v == 6'd0) begin
            return 6'd1;
        end
        return (v > hi) ? hi : v;
    endfunction

endpackage

@@ rtl/kcpn_ram.sv @@
// ----------------------------------------------------------------------------
// kcpn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kcpn_ram #(
    parameter int W = 32,
    parameter int D = 256
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/kron_column_projection_norm.sv @@
// ----------------------------------------------------------------------------
// kron_column_projection_norm
// Weighted Kronecker column of the gain matrix, projected through R, and its
// Euclidean norm minus a threshold, all in Q16.16.
// ----------------------------------------------------------------------------
// Load beats (gain, weight, R element) are taken one per cycle while the
// block is idle. A compute beat stalls the input until its result is
// registered: a source-pair split by repeated subtraction, each column
// element built in the read, multiply and write states through the shared
// 32x32 multiplier, one multiply-accumulate per cycle from the R and column
// RAM ports, and a 32-step square root. A finished result sits in the output
// register, so the next beat can be taken while it waits. A column at or
// beyond 2*S^2 gives no result.
// ----------------------------------------------------------------------------
module kron_column_projection_norm
    import kcpn_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in               i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out              o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // configuration
    logic [4:0]         r_sensor_count;
    logic [4:0]         r_source_count;
    logic [5:0]         r_time_count;
    logic signed [31:0] r_threshold;

    logic cfg_we;
    assign cfg_we = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor_count <= 5'd16;
            r_source_count <= 5'd16;
            r_time_count   <= 6'd32;
            r_threshold    <= '0;
        end else if (cfg_we) begin
            unique case (paddr[3:2])
                REG_SENSORS:   r_sensor_count <= pwdata[4:0];
                REG_SOURCES:   r_source_count <= pwdata[4:0];
                REG_TIME:      r_time_count   <= pwdata[5:0];
                REG_THRESHOLD: r_threshold    <= pwdata;
                default:       ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SENSORS:   prdata = {27'd0, r_sensor_count};
            REG_SOURCES:   prdata = {27'd0, r_source_count};
            REG_TIME:      prdata = {26'd0, r_time_count};
            REG_THRESHOLD: prdata = r_threshold;
            default:       prdata = '0;
        endcase
    end

    // effective sizes
    logic [4:0] ns, nsrc;
    logic [5:0] nt;
    logic [9:0] nn, sq;
    assign ns   = clamp5(r_sensor_count, 5'(MAX_SENSORS));
    assign nsrc = clamp5(r_source_count, 5'(MAX_SOURCES));
    assign nt   = clamp6(r_time_count, 6'(MAX_TIME));
    assign nn   = {5'd0, ns} * {5'd0, ns};
    assign sq   = {5'd0, nsrc} * {5'd0, nsrc};

    // state
    t_state r_state, n_state;

    logic [13:0]        r_addr;
    logic               r_half;
    logic [7:0]         r_q;
    logic [SRC_W-1:0]   r_i, r_j;
    logic [SEN_W-1:0]   r_k, r_l;
    logic [COL_AW-1:0]  r_cidx;
    logic [COL_AW:0]    r_m;
    logic [TIME_W-1:0]  r_t;
    logic               r_v1, r_v2;
    logic signed [31:0] r_opa;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_acc;
    logic signed [31:0] r_rsat;
    logic [63:0]        r_ss;
    logic [63:0]        r_res;
    logic [63:0]        r_bit;
    logic               r_out_valid;
    t_out               r_out;

    logic in_acc, out_free;
    assign in_acc     = i_in_valid & ~o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = ~r_out_valid | ~i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // memories
    logic                gain_we, weight_we, proj_we, col_we;
    logic [GAIN_AW-1:0]  gain_raddr;
    logic [31:0]         gain_rdata, weight_rdata, proj_rdata, col_rdata;
    logic [PROJ_AW-1:0]  proj_raddr;
    logic [ROW_W-1:0]    base, row_off;
    logic signed [31:0]  col_wdata;

    assign gain_we   = in_acc && (i_in.func == FUNC_GAIN)
                       && (i_in.addr < 14'(GAIN_DEPTH));
    assign weight_we = in_acc && (i_in.func == FUNC_WEIGHT)
                       && (i_in.addr < 14'(WEIGHT_DEPTH));
    assign proj_we   = in_acc && (i_in.func == FUNC_PROJ);

    assign base    = r_half ? nn[ROW_W-1:0] : '0;
    assign row_off = base + r_m[ROW_W-1:0];
    assign proj_raddr = {r_t, row_off};

    kcpn_ram #(.W(32), .D(GAIN_DEPTH)) u_gain (
        .i_clk(i_clk), .i_we(gain_we), .i_waddr(i_in.addr[GAIN_AW-1:0]),
        .i_wdata(i_in.value), .i_raddr(gain_raddr), .o_rdata(gain_rdata)
    );

    kcpn_ram #(.W(32), .D(WEIGHT_DEPTH)) u_weight (
        .i_clk(i_clk), .i_we(weight_we), .i_waddr(i_in.addr[WEIGHT_AW-1:0]),
        .i_wdata(i_in.value), .i_raddr(r_addr[WEIGHT_AW-1:0]),
        .o_rdata(weight_rdata)
    );

    kcpn_ram #(.W(32), .D(PROJ_DEPTH)) u_proj (
        .i_clk(i_clk), .i_we(proj_we), .i_waddr(i_in.addr[PROJ_AW-1:0]),
        .i_wdata(i_in.value), .i_raddr(proj_raddr), .o_rdata(proj_rdata)
    );

    kcpn_ram #(.W(32), .D(COL_DEPTH)) u_col (
        .i_clk(i_clk), .i_we(col_we), .i_waddr(r_cidx),
        .i_wdata(col_wdata), .i_raddr(r_m[COL_AW-1:0]), .o_rdata(col_rdata)
    );

    // shared multiplier and datapath helpers
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p, prod_q;
    logic               cb_last_k, cb_last_l, last_row, mac_drained;
    logic [64:0]        ss_sum;
    logic [63:0]        trial;
    logic signed [33:0] diff;
    logic               col_ok, half_n;
    logic [9:0]         q0;

    assign mul_p  = mul_a * mul_b;
    assign prod_q = r_prod >>> 16;
    assign col_wdata = sat32({{2{prod_q[63]}}, prod_q});

    assign cb_last_k   = ({1'b0, r_k} == (ns - 5'd1));
    assign cb_last_l   = ({1'b0, r_l} == (ns - 5'd1));
    assign last_row    = ({1'b0, r_t} == (nt - 6'd1));
    assign mac_drained = (r_m == nn[COL_AW:0]) && !r_v1 && !r_v2;
    assign ss_sum      = {1'b0, r_ss} + {1'b0, r_prod};
    assign trial       = r_res + r_bit;
    assign diff        = $signed({2'b00, r_res[31:0]}) - 34'(r_threshold);

    assign col_ok = r_addr < {3'd0, sq, 1'b0};
    assign half_n = r_addr >= {4'd0, sq};
    assign q0     = r_addr[9:0] - (half_n ? sq : 10'd0);

    always_comb begin
        mul_a      = r_opa;
        mul_b      = weight_rdata;
        gain_raddr = {r_i, r_k};
        col_we     = 1'b0;
        unique case (r_state)
            S_CB_RDL:  gain_raddr = {r_j, r_l};
            S_CB_MUL1: mul_b = gain_rdata;
            S_CB_WR:   col_we = 1'b1;
            S_MAC: begin
                mul_a = proj_rdata;
                mul_b = col_rdata;
            end
            S_SQ: begin
                mul_a = r_rsat;
                mul_b = r_rsat;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (in_acc && i_in.func == FUNC_COMPUTE) n_state = S_SETUP;
            S_SETUP:   n_state = col_ok ? S_DIV : S_IDLE;
            S_DIV:     if ({3'd0, nsrc} > r_q) n_state = S_CB_RDL;
            S_CB_RDL:  n_state = S_CB_RDK;
            S_CB_RDK:  n_state = S_CB_MUL1;
            S_CB_MUL1: n_state = S_CB_MUL2;
            S_CB_MUL2: n_state = S_CB_MUL3;
            S_CB_MUL3: n_state = S_CB_WR;
            S_CB_WR:   n_state = (cb_last_k && cb_last_l) ? S_MAC : S_CB_RDL;
            S_MAC:     if (mac_drained) n_state = S_ROW_END;
            S_ROW_END: n_state = S_SQ;
            S_SQ:      n_state = S_ACC;
            S_ACC:     n_state = last_row ? S_SQRT : S_MAC;
            S_SQRT:    if (r_bit[0]) n_state = S_DONE;
            S_DONE:    if (out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_ss        <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_SETUP: begin
                    r_ss <= '0;
                end
                S_ACC: begin
                    r_ss <= ss_sum[64] ? '1 : ss_sum[63:0];
                end
                S_SQRT: begin
                    if (r_ss >= trial) begin
                        r_ss <= r_ss - trial;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload and loop registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_addr <= i_in.addr;
                end
            end
            S_SETUP: begin
                r_half <= half_n;
                r_q    <= q0[7:0];
                r_j    <= '0;
            end
            S_DIV: begin
                if ({3'd0, nsrc} > r_q) begin
                    r_i    <= r_q[SRC_W-1:0];
                    r_k    <= '0;
                    r_l    <= '0;
                    r_cidx <= '0;
                end else begin
                    r_q <= r_q - {3'd0, nsrc};
                    r_j <= r_j + 1'b1;
                end
            end
            S_CB_RDK:  r_opa  <= gain_rdata;
            S_CB_MUL1: r_prod <= mul_p;
            S_CB_MUL2: r_opa  <= sat32({{2{prod_q[63]}}, prod_q});
            S_CB_MUL3: r_prod <= mul_p;
            S_CB_WR: begin
                r_cidx <= r_cidx + 1'b1;
                if (cb_last_k) begin
                    r_k <= '0;
                    r_l <= r_l + 1'b1;
                end else begin
                    r_k <= r_k + 1'b1;
                end
                r_m   <= '0;
                r_t   <= '0;
                r_acc <= '0;
                r_v1  <= 1'b0;
                r_v2  <= 1'b0;
            end
            S_MAC: begin
                if (r_m != nn[COL_AW:0]) begin
                    r_m  <= r_m + 1'b1;
                    r_v1 <= 1'b1;
                end else begin
                    r_v1 <= 1'b0;
                end
                r_v2 <= r_v1;
                if (r_v1) begin
                    r_prod <= mul_p;
                end
                if (r_v2) begin
                    r_acc <= r_acc + prod_q;
                end
            end
            S_ROW_END: r_rsat <= sat32({{2{r_acc[63]}}, r_acc});
            S_SQ:      r_prod <= mul_p;
            S_ACC: begin
                r_t   <= r_t + 1'b1;
                r_m   <= '0;
                r_acc <= '0;
                r_res <= '0;
                r_bit <= 64'd1 << 62;
            end
            S_SQRT: begin
                if (r_ss >= trial) begin
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            S_DONE: begin
                if (out_free) begin
                    r_out.column_index <= r_addr[8:0];
                    r_out.violation    <= sat32({{32{diff[33]}}, diff});
                end
            end
            default: ;
        endcase
    end

endmodule
